// ===== hw/rtl/efr_pkg.sv =====
// shared constants, types and crc function for the escaped frame receiver
package efr_pkg;

    localparam int CAPACITY = 256;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PL_W     = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [7:0]  ESC_BYTE  = 8'hF1;
    localparam logic [7:0]  TERM_BYTE = 8'hF2;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic       term;
        logic [7:0] data;
    } efr_op_t;

    // reflected crc-16 step for one byte, table entry form
    function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = {8'h00, crc[7:0] ^ b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c ^ {8'h00, crc[15:8]};
    endfunction

endpackage

// ===== hw/rtl/escaped_frame_receiver_crc16.sv =====
// top level of the escaped frame receiver with crc-16 check
// a result passes through the queue and then the result register after the byte that causes it is accepted
// throughput: one byte per cycle while the queue is not full, set by the single-step crc update in the back end
// the two-entry queue lets the front end keep taking bytes while a result waits
// reset: synchronous active-low aresetn clears escape state, queue, frame count and crc
// no clearing pass; the block accepts bytes in the first cycle after reset
module escaped_frame_receiver_crc16 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic        m_is_command,
    output logic [7:0]  m_payload_length,
    output logic [15:0] m_received_crc
);
    import efr_pkg::*;

    logic    q_full;
    logic    q_push;
    efr_op_t q_in;
    logic    q_valid;
    efr_op_t q_out;
    logic    q_pop;

    efr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (q_in)
    );

    efr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_op  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .op_valid (q_valid),
        .op       (q_out)
    );

    efr_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .op_valid         (q_valid),
        .op               (q_out),
        .op_ready         (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_data_byte      (m_data_byte),
        .m_is_command     (m_is_command),
        .m_payload_length (m_payload_length),
        .m_received_crc   (m_received_crc)
    );

endmodule

// ===== hw/rtl/efr_front.sv =====
// front end: strips escapes and classifies each byte as data or terminator
module efr_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_rx_byte,
    input  logic            q_full,
    output logic            q_push,
    output efr_pkg::efr_op_t q_op
);
    import efr_pkg::*;

    logic escape_reg;
    logic escape_next;
    logic accept;
    logic is_esc;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_esc  = !escape_reg && (s_rx_byte == ESC_BYTE);

    // an escape byte itself never reaches the queue
    assign q_push       = accept && !is_esc;
    assign q_op.term    = !escape_reg && (s_rx_byte == TERM_BYTE);
    assign q_op.data    = s_rx_byte;

    always_comb begin
        escape_next = escape_reg;
        if (accept) begin
            escape_next = is_esc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_reg <= 1'b0;
        end else begin
            escape_reg <= escape_next;
        end
    end

endmodule

// ===== hw/rtl/efr_queue.sv =====
// short request queue between front end and back end
module efr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  efr_pkg::efr_op_t push_op,
    output logic             full,
    input  logic             pop,
    output logic             op_valid,
    output efr_pkg::efr_op_t op
);
    import efr_pkg::*;

    efr_op_t           mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   count_reg,  count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == Q_CW'(Q_DEPTH));
    assign op_valid = (count_reg != '0);
    assign op       = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && op_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/efr_back.sv =====
// back end: frame store count, held crc bytes, running crc and result register
module efr_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             op_valid,
    input  efr_pkg::efr_op_t op,
    output logic             op_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_data_byte,
    output logic             m_is_command,
    output logic [7:0]       m_payload_length,
    output logic [15:0]      m_received_crc
);
    import efr_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg,   crc_next;
    logic [7:0]       older_reg, older_next;
    logic [7:0]       newer_reg, newer_next;

    logic             m_valid_reg, m_valid_next;
    logic [1:0]       kind_reg,  kind_next;
    logic [7:0]       data_reg,  data_next;
    logic             cmd_reg,   cmd_next;
    logic [7:0]       plen_reg,  plen_next;
    logic [15:0]      rxcrc_reg, rxcrc_next;

    logic             take;
    logic [15:0]      rx_crc;
    logic [PL_W-1:0]  plen_full;
    logic [7:0]       plen_sat;

    assign op_ready  = !m_valid_reg || m_ready;
    assign take      = op_valid && op_ready;
    assign rx_crc    = {newer_reg, older_reg};
    assign plen_full = PL_W'(count_reg) - PL_W'(3);
    assign plen_sat  = (plen_full > PL_W'(255)) ? 8'hFF : plen_full[7:0];

    always_comb begin
        count_next   = count_reg;
        crc_next     = crc_reg;
        older_next   = older_reg;
        newer_next   = newer_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        data_next    = data_reg;
        cmd_next     = cmd_reg;
        plen_next    = plen_reg;
        rxcrc_next   = rxcrc_reg;
        if (take) begin
            m_valid_next = 1'b0;
            if (op.term) begin
                // frames shorter than three bytes vanish without a verdict
                if (count_reg >= CNT_W'(3)) begin
                    m_valid_next = 1'b1;
                    kind_next    = (rx_crc == crc_reg) ? KIND_GOOD : KIND_ERR;
                    data_next    = '0;
                    cmd_next     = 1'b0;
                    plen_next    = plen_sat;
                    rxcrc_next   = rx_crc;
                end
                count_next = '0;
                crc_next   = '0;
            end else if (count_reg != CNT_W'(CAPACITY)) begin
                // the oldest held byte leaves once two newer ones are behind it
                if (count_reg >= CNT_W'(2)) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_DATA;
                    data_next    = older_reg;
                    cmd_next     = (count_reg == CNT_W'(2));
                    plen_next    = '0;
                    rxcrc_next   = '0;
                    crc_next     = crc_fold(crc_reg, older_reg);
                end
                older_next = newer_reg;
                newer_next = op.data;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            crc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        older_reg <= older_next;
        newer_reg <= newer_next;
        kind_reg  <= kind_next;
        data_reg  <= data_next;
        cmd_reg   <= cmd_next;
        plen_reg  <= plen_next;
        rxcrc_reg <= rxcrc_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_data_byte      = data_reg;
    assign m_is_command     = cmd_reg;
    assign m_payload_length = plen_reg;
    assign m_received_crc   = rxcrc_reg;

endmodule

// ===== hw/rtl/efr_checker.sv =====
// port-level checks for the escaped frame receiver, bound to the top level
module efr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_rx_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [7:0]  m_data_byte,
    input logic        m_is_command,
    input logic [7:0]  m_payload_length,
    input logic [15:0] m_received_crc
);
    import efr_pkg::*;

    // a waiting request keeps its byte until it is taken
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_rx_byte))
        else $error("request withdrawn or changed while waiting");

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == KIND_DATA || m_kind == KIND_GOOD || m_kind == KIND_ERR))
        else $error("result kind out of range");

    a_data_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_DATA |-> m_payload_length == 8'd0 && m_received_crc == 16'd0)
        else $error("verdict fields set on a data byte");

    a_verdict_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_DATA |-> m_data_byte == 8'd0 && !m_is_command)
        else $error("data fields set on a verdict");

endmodule

bind escaped_frame_receiver_crc16 efr_checker u_efr_checker (.*);
